[rtl/core/tcl_pkg.sv]
// Shared types and constants for the text cursor layout block.
// Holds the beat structs, the register map and the character codes.
// No dependencies.
package tcl_pkg;

	typedef struct packed {
		logic        first;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [7:0]  char_byte;
	} in_t;

	typedef struct packed {
		logic [15:0] glyph_x;
		logic [15:0] glyph_y;
		logic [15:0] glyph_code;
		logic        is_wide;
	} out_t;

	typedef struct packed {
		logic [7:0]  font_size;
		logic [15:0] screen_width;
		logic [15:0] screen_height;
	} cfg_t;

	localparam int unsigned ADDR_W = 4;

	localparam logic [1:0] REG_FONT_SIZE     = 2'd0;
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

	localparam logic [7:0]  RST_FONT_SIZE     = 8'd16;
	localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd240;
	localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd320;

	localparam logic [7:0] CHR_TERM       = 8'h00;
	localparam logic [7:0] CHR_NEWLINE    = 8'h0A;
	localparam logic [7:0] CHR_PRINT_LOW  = 8'h20;
	localparam logic [7:0] CHR_PRINT_HIGH = 8'h7E;
	localparam logic [7:0] CHR_LEAD_LOW   = 8'hA1;
	localparam logic [7:0] CHR_LEAD_HIGH  = 8'hF7;

endpackage

[rtl/core/tcl_regs.sv]
// Configuration registers of the text cursor layout block behind an APB-style port.
// Depends on tcl_pkg for the register map and reset values.
module tcl_regs
	import tcl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.font_size     <= RST_FONT_SIZE;
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FONT_SIZE:     cfg_q.font_size     <= pwdata[7:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[15:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FONT_SIZE:     prdata = {24'd0, cfg_q.font_size};
			REG_SCREEN_WIDTH:  prdata = {16'd0, cfg_q.screen_width};
			REG_SCREEN_HEIGHT: prdata = {16'd0, cfg_q.screen_height};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

[rtl/core/tcl_layout.sv]
// Input stage and cursor state of the text cursor layout block.
// One byte in the stage register is resolved per cycle against the cursor, while the result buffer is not full.
// Depends on tcl_pkg.
module tcl_layout
	import tcl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	input  logic res_full,
	output logic res_push,
	output out_t res_data
);

	logic        valid_s1;
	in_t         item_s1;

	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic        halted_q;
	logic        lead_pending_q;
	logic [7:0]  lead_code_q;

	logic [15:0] cursor_x_n;
	logic [15:0] cursor_y_n;
	logic        halted_n;
	logic        lead_pending_n;
	logic [7:0]  lead_code_n;
	logic        emit;
	logic        fire;

	assign fire     = valid_s1 && !res_full;
	assign in_ready = !valid_s1 || !res_full;
	assign res_push = fire && emit;

	always_comb begin
		logic [7:0]  b;
		logic [7:0]  fs;
		logic [7:0]  width;
		logic [15:0] cx;
		logic [15:0] cy;
		logic        halt_e;
		logic        lead_e;
		logic        is_lead;
		logic        is_nl;
		logic        wrap;
		b              = item_s1.char_byte;
		fs             = cfg.font_size;
		cx             = item_s1.first ? item_s1.start_x : cursor_x_q;
		cy             = item_s1.first ? item_s1.start_y : cursor_y_q;
		halt_e         = item_s1.first ? 1'b0 : halted_q;
		lead_e         = item_s1.first ? 1'b0 : lead_pending_q;
		is_lead        = (b >= CHR_LEAD_LOW) && (b <= CHR_LEAD_HIGH);
		width          = is_lead ? fs : {1'b0, fs[7:1]};
		is_nl          = (b == CHR_NEWLINE);
		wrap           = ({1'b0, cx} + {9'd0, width}) > {1'b0, cfg.screen_width};
		cursor_x_n     = cx;
		cursor_y_n     = cy;
		halted_n       = halt_e;
		lead_pending_n = lead_e;
		lead_code_n    = lead_code_q;
		emit           = 1'b0;
		res_data       = '{glyph_x: cx, glyph_y: cy, glyph_code: {8'd0, b}, is_wide: 1'b0};
		if (halt_e) begin
			// idle: drop the byte
		end else if (lead_e) begin
			lead_pending_n = 1'b0;
			if (b == CHR_TERM) begin
				halted_n = 1'b1;
			end else begin
				emit                = 1'b1;
				res_data.glyph_code = {lead_code_q, b};
				res_data.is_wide    = 1'b1;
				cursor_x_n          = cx + {8'd0, fs};
			end
		end else if (b == CHR_TERM) begin
			halted_n = 1'b1;
		end else begin
			if (is_nl || wrap) begin
				cy         = cy + {8'd0, fs};
				cx         = 16'd0;
				cursor_x_n = cx;
				cursor_y_n = cy;
			end
			res_data.glyph_x = cx;
			res_data.glyph_y = cy;
			if ((is_nl || wrap) &&
			    (({1'b0, cy} + {9'd0, fs}) > {1'b0, cfg.screen_height})) begin
				halted_n = 1'b1;
			end else if (is_nl) begin
				// line break only
			end else if (is_lead) begin
				lead_pending_n = 1'b1;
				lead_code_n    = b;
			end else begin
				emit       = (b >= CHR_PRINT_LOW) && (b <= CHR_PRINT_HIGH);
				cursor_x_n = cx + {8'd0, width};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= 16'd0;
			cursor_y_q     <= 16'd0;
			halted_q       <= 1'b1;
			lead_pending_q <= 1'b0;
			lead_code_q    <= 8'd0;
		end else if (fire) begin
			cursor_x_q     <= cursor_x_n;
			cursor_y_q     <= cursor_y_n;
			halted_q       <= halted_n;
			lead_pending_q <= lead_pending_n;
			lead_code_q    <= lead_code_n;
		end
	end

	a_push_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> valid_s1)
		else $error("result pushed without a byte in the stage");

	a_term_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.char_byte == CHR_TERM) |=> halted_q)
		else $error("terminator did not halt the layout");

	a_wide_clears_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.is_wide) |=> !lead_pending_q)
		else $error("lead still pending after a wide glyph");

	a_lead_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		lead_pending_q |-> !halted_q)
		else $error("lead pending while halted");

endmodule

[rtl/core/tcl_outq.sv]
// Two-entry result buffer of the text cursor layout block.
// Full is registered, so the input side never waits on out_ready directly.
// Depends on tcl_pkg.
module tcl_outq
	import tcl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  out_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	out_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/text_cursor_layout.sv]
// Top level of the text cursor layout block: registers, layout stage, result buffer.
// Depends on tcl_pkg, tcl_regs, tcl_layout and tcl_outq.
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+-------------------------------
//  in      | in        | in_valid / in_ready   | in_t: first, start x/y, byte
//  out     | out       | out_valid / out_ready | out_t: glyph x/y, code, wide
//  config  | in        | APB psel/penable      | font size, screen width/height
//
// One byte per cycle while the buffer is not full: a byte is held in the stage register,
// where the cursor add and wrap compares resolve it, and its glyph lands in the buffer.
// Reset leaves the cursor at 0,0 and idle until a byte with first set.
// With the two-entry buffer full the stage holds and in_ready drops.
module text_cursor_layout
	import tcl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data
);

	cfg_t cfg;
	logic res_full;
	logic res_push;
	out_t res_data;

	tcl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcl_layout u_layout (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	tcl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.full      (res_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[tb/tb.sv]
// Self-checking testbench for text_cursor_layout: directed table, then random strings.
// Depends on tcl_pkg and the block's RTL; predicts glyphs from its table or its cursor model.
// Register writes go over APB only while the block is idle.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcl_pkg::*;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_GLYPH,
		CHK_NONE
	} chk_e;

	typedef struct packed {
		in_t  beat;
		chk_e how;
		out_t want;
	} probe_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	in_t               in_data;
	logic              out_valid;
	logic              out_ready;
	out_t              out_data;

	text_cursor_layout dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// shadow registers and cursor state
	logic [7:0]  fsz;
	logic [15:0] scr_w;
	logic [15:0] scr_h;
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	bit          stopped;
	bit          lead_wait;
	logic [7:0]  lead_byte;

	out_t        glyphs_due [$];
	probe_t      probes [$];
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned beats_used;
	int unsigned glyphs_made;
	int unsigned glyphs_seen;
	int unsigned slips;
	int unsigned settings_run;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Works out the glyph, if any, that one accepted byte places.
	function automatic bit place_glyph(input in_t b, output out_t g);
		logic [7:0]  c;
		bit          lead;
		int unsigned w;
		int unsigned next_row;
		c = b.char_byte;
		g = '0;
		if (b.first) begin
			cur_x = b.start_x;
			cur_y = b.start_y;
			stopped = 1'b0;
			lead_wait = 1'b0;
		end
		if (stopped)
			return 1'b0;
		if (lead_wait) begin
			lead_wait = 1'b0;
			if (c == CHR_TERM) begin
				stopped = 1'b1;
				return 1'b0;
			end
			g.glyph_x = cur_x;
			g.glyph_y = cur_y;
			g.glyph_code = {lead_byte, c};
			g.is_wide = 1'b1;
			cur_x = 16'(cur_x + fsz);
			return 1'b1;
		end
		if (c == CHR_TERM) begin
			stopped = 1'b1;
			return 1'b0;
		end
		lead = (c >= CHR_LEAD_LOW) && (c <= CHR_LEAD_HIGH);
		w = lead ? 32'(fsz) : 32'(fsz >> 1);
		// compare at full width; only the stored cursor wraps
		if (c == CHR_NEWLINE || w + 32'(cur_x) > 32'(scr_w)) begin
			cur_y = 16'(cur_y + fsz);
			cur_x = '0;
			next_row = 32'(cur_y) + 32'(fsz);
			if (next_row > 32'(scr_h)) begin
				stopped = 1'b1;
				return 1'b0;
			end
			if (c == CHR_NEWLINE)
				return 1'b0;
		end
		if (lead) begin
			lead_wait = 1'b1;
			lead_byte = c;
			return 1'b0;
		end
		if (c >= CHR_PRINT_LOW && c <= CHR_PRINT_HIGH) begin
			g.glyph_x = cur_x;
			g.glyph_y = cur_y;
			g.glyph_code = {8'h00, c};
			g.is_wide = 1'b0;
			cur_x = 16'(32'(cur_x) + w);
			return 1'b1;
		end
		cur_x = 16'(32'(cur_x) + w);
		return 1'b0;
	endfunction

	function automatic probe_t row(input bit first, input int unsigned x, input int unsigned y,
			input logic [7:0] c, input chk_e how, input int unsigned gx, input int unsigned gy,
			input int unsigned code, input bit wide);
		probe_t p;
		p.beat.first = first;
		p.beat.start_x = 16'(x);
		p.beat.start_y = 16'(y);
		p.beat.char_byte = c;
		p.how = how;
		p.want.glyph_x = 16'(gx);
		p.want.glyph_y = 16'(gy);
		p.want.glyph_code = 16'(code);
		p.want.is_wide = wide;
		return p;
	endfunction

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 8'($urandom_range(CHR_PRINT_LOW, CHR_PRINT_HIGH));
		if (r < 70)
			return 8'($urandom_range(CHR_LEAD_LOW, CHR_LEAD_HIGH));
		if (r < 77)
			return CHR_NEWLINE;
		if (r < 80)
			return CHR_TERM;
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_coord(input logic [15:0] limit);
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'($urandom);
		if (r == 1)
			return limit;
		return 16'($urandom_range(0, limit));
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic push_byte(input in_t b, input chk_e how, input out_t want);
		out_t g;
		bit   made;
		while ($urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		made = place_glyph(b, g);
		beats_used++;
		case (how)
			CHK_GLYPH: begin
				glyphs_due.push_back(want);
				glyphs_made++;
			end
			CHK_NONE: ;
			default: begin
				if (made) begin
					glyphs_due.push_back(g);
					glyphs_made++;
				end
			end
		endcase
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_FONT_SIZE:     fsz = val[7:0];
			REG_SCREEN_WIDTH:  scr_w = val[15:0];
			REG_SCREEN_HEIGHT: scr_h = val[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic read_reg(input logic [1:0] idx);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_FONT_SIZE:     want = {24'd0, fsz};
			REG_SCREEN_WIDTH:  want = {16'd0, scr_w};
			default:           want = {16'd0, scr_h};
		endcase
		if (prdata !== want) begin
			$error("prdata at register %0d: expected %0h, got %0h", idx, want, prdata);
			slips++;
		end
		@(negedge clk);
	endtask

	task automatic read_all();
		read_reg(REG_FONT_SIZE);
		read_reg(REG_SCREEN_WIDTH);
		read_reg(REG_SCREEN_HEIGHT);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_layout(input logic [7:0] f, input logic [15:0] w, input logic [15:0] h);
		write_reg(REG_FONT_SIZE, {24'd0, f});
		write_reg(REG_SCREEN_WIDTH, {16'd0, w});
		write_reg(REG_SCREEN_HEIGHT, {16'd0, h});
		read_all();
		settings_run++;
	endtask

	// Hold until every glyph is back, then let the two-stage pipe empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (glyphs_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_strings(input int unsigned quota);
		in_t         b;
		int unsigned len;
		int unsigned beats0;
		beats0 = beats_used;
		while (beats_used - beats0 < quota) begin
			// some noise while idle: bytes without a string start are dropped
			if (stopped && $urandom_range(9) == 0) begin
				b.first = 1'b0;
				b.start_x = 16'($urandom);
				b.start_y = 16'($urandom);
				b.char_byte = 8'($urandom);
				push_byte(b, CHK_MODEL, '0);
				continue;
			end
			b.first = 1'b1;
			b.start_x = pick_coord(scr_w);
			b.start_y = pick_coord(scr_h);
			b.char_byte = pick_char();
			push_byte(b, CHK_MODEL, '0);
			len = $urandom_range(1, 40);
			repeat (len) begin
				b.first = ($urandom_range(49) == 0);
				b.start_x = 16'($urandom);
				b.start_y = 16'($urandom);
				b.char_byte = pick_char();
				push_byte(b, CHK_MODEL, '0);
			end
			if ($urandom_range(3) != 0) begin
				b.first = 1'b0;
				b.char_byte = CHR_TERM;
				push_byte(b, CHK_MODEL, '0);
			end
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin : glyph_check
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			glyphs_seen++;
			if (glyphs_due.size() == 0) begin
				$error("glyph beat with nothing expected: %0h", out_data);
				slips++;
			end else begin
				want = glyphs_due.pop_front();
				if (out_data.glyph_x !== want.glyph_x) begin
					$error("glyph_x: expected %0d, got %0d", want.glyph_x, out_data.glyph_x);
					slips++;
				end
				if (out_data.glyph_y !== want.glyph_y) begin
					$error("glyph_y: expected %0d, got %0d", want.glyph_y, out_data.glyph_y);
					slips++;
				end
				if (out_data.glyph_code !== want.glyph_code) begin
					$error("glyph_code: expected %0h, got %0h", want.glyph_code,
						out_data.glyph_code);
					slips++;
				end
				if (out_data.is_wide !== want.is_wide) begin
					$error("is_wide: expected %0b, got %0b", want.is_wide, out_data.is_wide);
					slips++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [7:0]  ph_font [6];
		logic [15:0] ph_width [6];
		logic [15:0] ph_height [6];
		ph_font = '{8'd16, 8'd2, 8'd255, 8'd1, 8'd0, 8'd16};
		ph_width = '{16'd240, 16'd1, 16'd65535, 16'd37, 16'd65535, 16'd240};
		ph_height = '{16'd320, 16'd65535, 16'd65535, 16'd1, 16'd1, 16'd320};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		send_gap = 14;
		recv_stall = 81;
		beats_used = 0;
		glyphs_made = 0;
		glyphs_seen = 0;
		slips = 0;
		settings_run = 1;
		fsz = RST_FONT_SIZE;
		scr_w = RST_SCREEN_WIDTH;
		scr_h = RST_SCREEN_HEIGHT;
		cur_x = '0;
		cur_y = '0;
		stopped = 1'b1;
		lead_wait = 1'b0;
		lead_byte = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		read_all();

		// directed table at reset settings: 16 high, narrow 8, wide 16
		probes.push_back(row(1, 0, 0, 8'h41, CHK_GLYPH, 0, 0, 16'h0041, 0));
		probes.push_back(row(0, 0, 0, CHR_PRINT_LOW, CHK_GLYPH, 8, 0, 16'h0020, 0));
		probes.push_back(row(0, 0, 0, CHR_PRINT_HIGH, CHK_GLYPH, 16, 0, 16'h007E, 0));
		probes.push_back(row(0, 0, 0, 8'h7F, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, 8'h1F, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, CHR_NEWLINE, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, CHR_LEAD_LOW, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, CHR_NEWLINE, CHK_GLYPH, 0, 16, 16'hA10A, 1));
		probes.push_back(row(0, 0, 0, CHR_LEAD_HIGH, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, 8'hFF, CHK_GLYPH, 16, 16, 16'hF7FF, 1));
		probes.push_back(row(0, 0, 0, 8'hF8, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, 8'hA0, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, 8'hB0, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, CHR_TERM, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 16'hFFFF, 16'hFFFF, 8'h41, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(1, 232, 0, 8'h42, CHK_GLYPH, 232, 0, 16'h0042, 0));
		probes.push_back(row(0, 0, 0, 8'h43, CHK_GLYPH, 0, 16, 16'h0043, 0));
		probes.push_back(row(1, 0, 304, CHR_NEWLINE, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, 8'h44, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(1, 16'hFFFF, 16'hFFFF, 8'h41, CHK_MODEL, 0, 0, 0, 0));
		probes.push_back(row(1, 10, 10, 8'hC0, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(1, 20, 20, 8'h44, CHK_GLYPH, 20, 20, 16'h0044, 0));
		probes.push_back(row(1, 232, 0, CHR_LEAD_LOW, CHK_NONE, 0, 0, 0, 0));
		probes.push_back(row(0, 0, 0, 8'hA2, CHK_GLYPH, 0, 16, 16'hA1A2, 1));
		probes.push_back(row(1, 0, 0, CHR_TERM, CHK_NONE, 0, 0, 0, 0));
		foreach (probes[i])
			push_byte(probes[i].beat, probes[i].how, probes[i].want);

		for (int ph = 0; ph < 6; ph++) begin
			send_gap = (ph < 2) ? 14 : (ph < 4) ? 81 : 0;
			recv_stall = (ph < 2) ? 81 : (ph < 4) ? 14 : 0;
			if (ph != 0) begin
				drain();
				if (ph == 5)
					set_layout(8'($urandom_range(2, 255)), 16'($urandom_range(1, 65535)),
						16'($urandom_range(1, 65535)));
				else
					set_layout(ph_font[ph], ph_width[ph], ph_height[ph]);
			end
			run_strings(300);
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Covered %0d string bytes and %0d glyph beats under %0d register settings,",
			beats_used, glyphs_seen, settings_run);
		$display("with sender gaps and receiver stalls in both balances and at full rate.");
		if (slips == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

[text_cursor_layout.f]
rtl/core/tcl_pkg.sv
rtl/core/tcl_regs.sv
rtl/core/tcl_layout.sv
rtl/core/tcl_outq.sv
rtl/core/text_cursor_layout.sv
tb/tb.sv
